/* rtl/core/pfmt_pkg.sv */
// ----------------------------------------------------------------------------
// pfmt_pkg
// Shared constants and a helper for the printf specifier formatter core.
// ----------------------------------------------------------------------------
package pfmt_pkg;

  // field widths
  localparam int ACTION_W = 8;
  localparam int ARG_W    = 32;
  localparam int CHAR_W   = 8;
  localparam int COUNT_W  = 4;

  // decimal conversion sizes
  localparam int NDIGITS  = 10;
  localparam int BCD_W    = 4 * NDIGITS;
  localparam int BITCNT_W = $clog2(ARG_W);

  // ascii codes
  localparam logic [CHAR_W-1:0] CH_C       = 8'h63;
  localparam logic [CHAR_W-1:0] CH_PERCENT = 8'h25;
  localparam logic [CHAR_W-1:0] CH_D       = 8'h64;
  localparam logic [CHAR_W-1:0] CH_I       = 8'h69;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2d;

  // double-dabble correction: add 3 to every bcd digit of 5 or more
  function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] bcd);
    logic [BCD_W-1:0] res;
    res = bcd;
    for (int k = 0; k < NDIGITS; k++) begin
      if (bcd[4*k +: 4] > 4'd4) begin
        res[4*k +: 4] = bcd[4*k +: 4] + 4'd3;
      end
    end
    return res;
  endfunction

endpackage

/* rtl/core/printf_specifier_formatter_core.sv */
// ----------------------------------------------------------------------------
// printf_specifier_formatter_core
// Formats one conversion specifier and its argument as ascii characters.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_*: one word is a specifier byte (in_action) and a 32-bit
//   signed argument (in_argument). It is taken when in_valid is high and
//   in_stall is low. in_stall is high while an item is being worked on.
//   Output channel out_*: one ascii character per word; out_last marks the
//   final character of an item and out_char_count then gives the number of
//   characters for the item (0 on the other words).
//   'c' gives the low argument byte, '%' gives a percent sign, 'd' and 'i'
//   give the signed decimal text, any other byte gives '%' and that byte.
// Operation:
//   'c', '%' and other echoed specifiers go from idle straight to emitting.
//   Decimal items run a bit-serial binary to bcd converter, one argument bit
//   per cycle, then drop one leading zero digit per cycle, keeping at least
//   one, then send one character per cycle while the output is not stalled.
// Reset: rst_n (synchronous) empties the block; no item state is kept.
// Stall: while out_stall is high a waiting output word holds and emitting waits;
// a new input word is taken while the last character still waits.
// ----------------------------------------------------------------------------
module printf_specifier_formatter_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [pfmt_pkg::ACTION_W-1:0]  in_action,
  input  logic signed [pfmt_pkg::ARG_W-1:0] in_argument,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [pfmt_pkg::CHAR_W-1:0]    out_char,
  output logic                           out_last,
  output logic [pfmt_pkg::COUNT_W-1:0]   out_char_count
);
  import pfmt_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_SKIP, ST_EMIT} state_t;
  typedef enum logic [1:0] {K_CHR, K_PCT, K_ECHO, K_DEC} kind_t;

  state_t                state_r, state_nxt;
  kind_t                 kind_r, kind_nxt;
  logic [CHAR_W-1:0]     lit_r, lit_nxt;
  logic                  neg_r, neg_nxt;
  logic                  first_r, first_nxt;
  logic [ARG_W-1:0]      bin_r, bin_nxt;
  logic [BCD_W-1:0]      bcd_r, bcd_nxt;
  logic [BITCNT_W-1:0]   bitcnt_r, bitcnt_nxt;
  logic [COUNT_W-1:0]    ndig_r, ndig_nxt;
  logic [COUNT_W-1:0]    rem_r, rem_nxt;
  logic [COUNT_W-1:0]    cnt_r, cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]     out_char_r, out_char_nxt;
  logic                  out_last_r, out_last_nxt;
  logic [COUNT_W-1:0]    out_count_r, out_count_nxt;

  logic                  emit_ok;
  logic [BCD_W-1:0]      bcd_adj;
  logic [ARG_W-1:0]      arg_u;
  logic [CHAR_W-1:0]     ch;

  assign emit_ok = !out_valid_r || !out_stall;
  assign bcd_adj = bcd_adjust(bcd_r);
  assign arg_u   = ARG_W'(in_argument);

  // next-state and datapath logic
  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    lit_nxt       = lit_r;
    neg_nxt       = neg_r;
    first_nxt     = first_r;
    bin_nxt       = bin_r;
    bcd_nxt       = bcd_r;
    bitcnt_nxt    = bitcnt_r;
    ndig_nxt      = ndig_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_count_nxt = out_count_r;
    ch            = lit_r;

    // output word taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          first_nxt = 1'b1;
          case (in_action)
            CH_C: begin
              kind_nxt  = K_CHR;
              lit_nxt   = arg_u[CHAR_W-1:0];
              rem_nxt   = COUNT_W'(1);
              cnt_nxt   = COUNT_W'(1);
              state_nxt = ST_EMIT;
            end
            CH_PERCENT: begin
              kind_nxt  = K_PCT;
              lit_nxt   = CH_PERCENT;
              rem_nxt   = COUNT_W'(1);
              cnt_nxt   = COUNT_W'(1);
              state_nxt = ST_EMIT;
            end
            CH_D, CH_I: begin
              kind_nxt   = K_DEC;
              neg_nxt    = arg_u[ARG_W-1];
              bin_nxt    = arg_u[ARG_W-1] ? (ARG_W'(0) - arg_u) : arg_u;
              bcd_nxt    = '0;
              bitcnt_nxt = '0;
              state_nxt  = ST_CONV;
            end
            default: begin
              kind_nxt  = K_ECHO;
              lit_nxt   = in_action;
              rem_nxt   = COUNT_W'(2);
              cnt_nxt   = COUNT_W'(2);
              state_nxt = ST_EMIT;
            end
          endcase
        end
      end

      // one binary bit into the bcd register per cycle
      ST_CONV: begin
        bcd_nxt    = {bcd_adj[BCD_W-2:0], bin_r[ARG_W-1]};
        bin_nxt    = {bin_r[ARG_W-2:0], 1'b0};
        bitcnt_nxt = bitcnt_r + 1'b1;
        if (bitcnt_r == BITCNT_W'(ARG_W - 1)) begin
          ndig_nxt  = COUNT_W'(NDIGITS);
          state_nxt = ST_SKIP;
        end
      end

      // drop leading zero digits, keep at least one
      ST_SKIP: begin
        if (bcd_r[BCD_W-1 -: 4] == 4'd0 && ndig_r > COUNT_W'(1)) begin
          bcd_nxt  = {bcd_r[BCD_W-5:0], 4'd0};
          ndig_nxt = ndig_r - 1'b1;
        end else begin
          rem_nxt   = ndig_r + COUNT_W'(neg_r);
          cnt_nxt   = ndig_r + COUNT_W'(neg_r);
          first_nxt = neg_r;
          state_nxt = ST_EMIT;
        end
      end

      // one character per cycle into the output register while the output is not held
      ST_EMIT: begin
        if (emit_ok) begin
          case (kind_r)
            K_DEC: begin
              if (first_r) begin
                ch = CH_MINUS;
              end else begin
                ch      = CH_ZERO + CHAR_W'(bcd_r[BCD_W-1 -: 4]);
                bcd_nxt = {bcd_r[BCD_W-5:0], 4'd0};
              end
            end
            K_ECHO: begin
              ch = first_r ? CH_PERCENT : lit_r;
            end
            default: begin
              ch = lit_r;
            end
          endcase
          first_nxt     = 1'b0;
          out_valid_nxt = 1'b1;
          out_char_nxt  = ch;
          out_last_nxt  = (rem_r == COUNT_W'(1));
          out_count_nxt = (rem_r == COUNT_W'(1)) ? cnt_r : '0;
          rem_nxt       = rem_r - 1'b1;
          if (rem_r == COUNT_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    kind_r      <= kind_nxt;
    lit_r       <= lit_nxt;
    neg_r       <= neg_nxt;
    first_r     <= first_nxt;
    bin_r       <= bin_nxt;
    bcd_r       <= bcd_nxt;
    bitcnt_r    <= bitcnt_nxt;
    ndig_r      <= ndig_nxt;
    rem_r       <= rem_nxt;
    cnt_r       <= cnt_nxt;
    out_char_r  <= out_char_nxt;
    out_last_r  <= out_last_nxt;
    out_count_r <= out_count_nxt;
  end

  assign in_stall       = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_char       = out_char_r;
  assign out_last       = out_last_r;
  assign out_char_count = out_count_r;

  // checks
  a_last_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_char_count != '0)
    else $error("last word carries zero count");

  a_mid_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_char_count == '0)
    else $error("count set on a word that is not last");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("block not busy after taking an item");

  a_emit_rem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> rem_r != '0)
    else $error("emitting with no characters left");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_char_count <= COUNT_W'(NDIGITS + 1))
    else $error("character count out of range");

endmodule

/* tb/sv/printf_specifier_formatter_core_tb.sv */
// ----------------------------------------------------------------------------
// printf_specifier_formatter_core_tb
// Checks the specifier formatter against a character-level predictor.
// A short table of directed words covers the field extremes, every
// specifier class, the most negative argument, 's' and the zero byte.
// Random words follow, mostly 'd'/'i'/'c'/'%' with arguments spread over
// every digit count. Both channels idle in random bursts except near the end.
// ----------------------------------------------------------------------------
module printf_specifier_formatter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pfmt_pkg::*;

  // specifier and argument codes not found in the package
  localparam logic [ACTION_W-1:0] CH_S       = 8'h73;
  localparam logic [ACTION_W-1:0] CH_UPPER_D = 8'h44;
  localparam logic [ACTION_W-1:0] CH_NUL     = 8'h00;
  localparam logic [ACTION_W-1:0] ACT_MAX    = 8'hff;
  localparam logic [ARG_W-1:0]    ARG_A      = 32'h0000_0041;
  localparam logic [ARG_W-1:0]    ARG_MIN    = 32'h8000_0000;
  localparam logic [ARG_W-1:0]    ARG_MAX    = 32'h7fff_ffff;

  localparam int N_DIR          = 18;
  localparam int N_RAND         = 142;
  localparam int N_CALM         = 20;
  localparam int TAIL_CYCLES    = 64;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef logic [CHAR_W-1:0] text_t[$];

  typedef struct {
    logic [CHAR_W-1:0]  ch;
    logic               last;
    logic [COUNT_W-1:0] count;
  } fmt_char_t;

  typedef struct {
    logic [ACTION_W-1:0] act;
    logic [ARG_W-1:0]    arg;
    string               typed;
  } spec_row_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [ACTION_W-1:0]         in_action = '0;
  logic signed [ARG_W-1:0]     in_argument = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [CHAR_W-1:0]           out_char;
  logic                        out_last;
  logic [COUNT_W-1:0]          out_char_count;

  fmt_char_t pending_chars[$];
  int        fail_count = 0;
  bit        no_idle = 1'b0;

  // directed words; typed text only where it is obvious
  spec_row_t dir_rows [N_DIR] = '{
    '{CH_D,       32'h0000_0000, "0"},
    '{CH_D,       ARG_MIN,       "-2147483648"},
    '{CH_D,       ARG_MAX,       "2147483647"},
    '{CH_I,       32'hffff_ffff, "-1"},
    '{CH_I,       32'd9,         ""},
    '{CH_D,       32'd10,        ""},
    '{CH_I,       32'd1000000000, ""},
    '{CH_D,       32'hc465_3601, ""},
    '{CH_I,       32'h8000_0001, ""},
    '{CH_D,       32'd1,         ""},
    '{CH_C,       ARG_A,         "A"},
    '{CH_C,       32'hffff_ff00, ""},
    '{CH_C,       32'h1234_56ff, ""},
    '{CH_PERCENT, 32'hdead_beef, "%"},
    '{CH_S,       32'h0000_0000, "%s"},
    '{CH_NUL,     32'hffff_ffff, ""},
    '{ACT_MAX,    32'h0000_0000, ""},
    '{CH_UPPER_D, 32'h5555_aaaa, ""}
  };

  printf_specifier_formatter_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_argument    (in_argument),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_char       (out_char),
    .out_last       (out_last),
    .out_char_count (out_char_count)
  );

  always #1 clk = ~clk;

  // text that one specifier and argument produce
  function automatic text_t format_spec(input logic [ACTION_W-1:0] act,
                                        input logic [ARG_W-1:0] arg);
    text_t       text;
    text_t       digits;
    logic [ARG_W-1:0] mag;
    case (act)
      CH_C: text.push_back(arg[CHAR_W-1:0]);
      CH_PERCENT: text.push_back(CH_PERCENT);
      CH_D, CH_I: begin
        if (arg[ARG_W-1]) begin
          text.push_back(CH_MINUS);
          mag = 32'd0 - arg;
        end else begin
          mag = arg;
        end
        do begin
          digits.push_front(CHAR_W'(CH_ZERO + mag % 10));
          mag = mag / 10;
        end while (mag != 0);
        foreach (digits[k]) text.push_back(digits[k]);
      end
      default: begin
        text.push_back(CH_PERCENT);
        text.push_back(act);
      end
    endcase
    return text;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  // drive one word, wait for it to be taken, then queue its characters
  task automatic send_spec(input logic [ACTION_W-1:0] act, input logic [ARG_W-1:0] arg,
                           input string typed);
    text_t text;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_action   <= act;
    in_argument <= arg;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (typed.len() != 0) begin
      for (int k = 0; k < typed.len(); k++) text.push_back(typed[k]);
    end else begin
      text = format_spec(act, arg);
    end
    for (int k = 0; k < text.size(); k++) begin
      fmt_char_t c;
      c.ch    = text[k];
      c.last  = (k == text.size() - 1);
      c.count = c.last ? COUNT_W'(text.size()) : '0;
      pending_chars.push_back(c);
    end
  endtask

  // output stall in bursts, with longer quiet stretches between them
  initial begin : out_stall_gen
    int n;
    @(posedge clk);
    forever begin
      if (no_idle || $urandom_range(0, 2) != 0) begin
        out_stall <= 1'b0;
        n = $urandom_range(1, 40);
      end else begin
        out_stall <= 1'b1;
        n = $urandom_range(1, 12);
      end
      repeat (n) @(posedge clk);
    end
  end

  // compare each accepted character with the oldest pending one
  always @(posedge clk) begin : check_out
    fmt_char_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected word char=%02h last=%0b count=%0d",
                                  out_char, out_last, out_char_count));
      end else begin
        want = pending_chars.pop_front();
        if (out_char !== want.ch)
          report_mismatch($sformatf("char %02h, want %02h", out_char, want.ch));
        if (out_last !== want.last)
          report_mismatch($sformatf("last %0b, want %0b", out_last, want.last));
        if (out_char_count !== want.count)
          report_mismatch($sformatf("char_count %0d, want %0d",
                                    out_char_count, want.count));
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("[%0t] timeout, %0d characters still pending", $realtime,
             pending_chars.size());
    $display("Simulation FAILED");
    $finish;
  end

  // reset, directed table, random words, drain
  initial begin : main_seq
    logic [ACTION_W-1:0] act;
    logic [ARG_W-1:0]    arg;
    int                  sel;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < N_DIR; r++) begin
      send_spec(dir_rows[r].act, dir_rows[r].arg, dir_rows[r].typed);
    end

    for (int r = 0; r < N_RAND; r++) begin
      if (r >= N_RAND - N_CALM) no_idle = 1'b1;
      sel = $urandom_range(0, 99);
      if (sel < 30)      act = CH_D;
      else if (sel < 50) act = CH_I;
      else if (sel < 65) act = CH_C;
      else if (sel < 75) act = CH_PERCENT;
      else               act = ACTION_W'($urandom_range(0, 255));
      case ($urandom_range(0, 3))
        0: arg = $urandom();
        1: arg = $urandom_range(0, 99);
        2: arg = 32'd0 - ARG_W'($urandom_range(1, 1000));
        default: begin
          arg = $urandom() >> $urandom_range(0, 31);
          if ($urandom_range(0, 1) == 1) arg = 32'd0 - arg;
        end
      endcase
      send_spec(act, arg, "");
    end
    in_valid <= 1'b0;

    // drain and watch for stray words
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
